@@ hdl/tlfc_pkg.sv @@
// Shared constants, window-size helper functions and the status struct for the trend line fit.
`default_nettype none

package tlfc_pkg;

   // Default number of samples in one fit window.
   localparam int TLFC_WINDOW_POINTS = 16;

   // Fixed field widths.
   localparam int SAMPLE_W  = 16;
   localparam int GLUCOSE_W = 16;
   localparam int CLIMB_W   = 8;
   localparam int CLASS_W   = 3;

   // Quotient widths of the two constant dividers. The slope magnitude is
   // at most 128 inside the unsaturated range.
   localparam int ICPT_Q_W  = 16;
   localparam int SLOPE_Q_W = 8;

   // Trend class codes.
   localparam logic [CLASS_W-1:0] TREND_RISING       = 3'd0;
   localparam logic [CLASS_W-1:0] TREND_RISING_SLOW  = 3'd1;
   localparam logic [CLASS_W-1:0] TREND_CONSTANT     = 3'd2;
   localparam logic [CLASS_W-1:0] TREND_FALLING_SLOW = 3'd3;
   localparam logic [CLASS_W-1:0] TREND_FALLING      = 3'd4;
   localparam logic [CLASS_W-1:0] TREND_UNKNOWN      = 3'd5;

   // Range and threshold flags of one fit, carried beside the dividers.
   typedef struct packed {
      logic icpt_neg;
      logic icpt_hi;
      logic slope_neg;
      logic slope_hi;
      logic slope_lo;
      logic gt_p1280;
      logic lt_p5120;
      logic gt_p256;
      logic gt_m256;
      logic gt_m1280;
      logic le_m1281;
      logic gt_m5120;
   } tlfc_flags_type;

   function automatic int tlfc_maxi(int a, int b);
      return (a > b) ? a : b;
   endfunction

   // Magnitude of the sum of x positions: x runs from -(n-1) to 0.
   function automatic int tlfc_sum_x_mag(int n);
      return n * (n - 1) / 2;
   endfunction

   function automatic int tlfc_sum_x2(int n);
      return (n - 1) * n * (2 * n - 1) / 6;
   endfunction

   function automatic longint tlfc_divisor(int n);
      longint h;
      h = longint'(tlfc_sum_x_mag(n));
      return longint'(n) * longint'(tlfc_sum_x2(n)) - h * h;
   endfunction

   // Width of the sum of samples.
   function automatic int tlfc_sy_width(int n);
      return SAMPLE_W + $clog2(n);
   endfunction

   // Width of the sum of |x| times sample.
   function automatic int tlfc_w_width(int n);
      return SAMPLE_W + $clog2(tlfc_sum_x_mag(n) + 1);
   endfunction

endpackage

`default_nettype wire

@@ hdl/tlfc_accum.sv @@
// Window accumulator: sample count, sum of samples and sum of |x| times sample.
`default_nettype none

module tlfc_accum
   import tlfc_pkg::*;
#(
   parameter int WINDOW_POINTS = TLFC_WINDOW_POINTS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   in_valid,
   input  wire logic [SAMPLE_W-1:0]                    in_sample,
   output logic                                        win_valid,
   output logic [tlfc_sy_width(WINDOW_POINTS)-1:0]     win_sy,
   output logic [tlfc_w_width(WINDOW_POINTS)-1:0]      win_w
);

   localparam int YW    = tlfc_sy_width(WINDOW_POINTS);
   localparam int WGW   = tlfc_w_width(WINDOW_POINTS);
   localparam int CNT_W = $clog2(WINDOW_POINTS);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [YW-1:0]    sy_ff, sy_in;
   logic [WGW-1:0]   w_ff, w_in;
   logic             win_valid_ff, win_valid_in;
   logic [YW-1:0]    win_sy_ff, win_sy_in;
   logic [WGW-1:0]   win_w_ff, win_w_in;

   logic             take;
   logic             last;
   logic [YW-1:0]    sy_sum;
   logic [WGW-1:0]   w_sum;

   // The weighted sum is the running sum of prefix sums: each step adds the
   // sum of all earlier samples, which weights sample k by (N-1-k).
   always_comb begin
      take   = in_valid & en;
      last   = (count_ff == CNT_W'(WINDOW_POINTS - 1));
      sy_sum = sy_ff + YW'(in_sample);
      w_sum  = w_ff + WGW'(sy_ff);

      count_in     = count_ff;
      sy_in        = sy_ff;
      w_in         = w_ff;
      win_valid_in = take & last;
      win_sy_in    = sy_sum;
      win_w_in     = w_sum;
      if (take) begin
         if (last) begin
            count_in = '0;
            sy_in    = '0;
            w_in     = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sy_in    = sy_sum;
            w_in     = w_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sy_ff        <= '0;
         w_ff         <= '0;
         win_valid_ff <= 1'b0;
      end else if (en) begin
         count_ff     <= count_in;
         sy_ff        <= sy_in;
         w_ff         <= w_in;
         win_valid_ff <= win_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_sy_ff <= win_sy_in;
         win_w_ff  <= win_w_in;
      end
   end

   assign win_valid = win_valid_ff;
   assign win_sy    = win_sy_ff;
   assign win_w     = win_w_ff;

endmodule

`default_nettype wire

@@ hdl/tlfc_numer.sv @@
// Fit numerators, range flags, threshold flags and dividend magnitudes.
`default_nettype none

module tlfc_numer
   import tlfc_pkg::*;
#(
   parameter int WINDOW_POINTS = TLFC_WINDOW_POINTS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   in_valid,
   input  wire logic [tlfc_sy_width(WINDOW_POINTS)-1:0] in_sy,
   input  wire logic [tlfc_w_width(WINDOW_POINTS)-1:0]  in_w,
   output logic                                        out_valid,
   output tlfc_flags_type                              out_flags,
   output logic [SLOPE_Q_W+$clog2(tlfc_divisor(WINDOW_POINTS)+1)-1:0] out_smag,
   output logic [ICPT_Q_W+$clog2(tlfc_divisor(WINDOW_POINTS)+1)-1:0]  out_imag
);

   localparam int     YW    = tlfc_sy_width(WINDOW_POINTS);
   localparam int     WGW   = tlfc_w_width(WINDOW_POINTS);
   localparam int     H     = tlfc_sum_x_mag(WINDOW_POINTS);
   localparam int     SX2   = tlfc_sum_x2(WINDOW_POINTS);
   localparam longint DIV_L = tlfc_divisor(WINDOW_POINTS);
   localparam int     DW    = $clog2(DIV_L + 1);
   localparam int     SA_W  = SLOPE_Q_W + DW;
   localparam int     IA_W  = ICPT_Q_W + DW;
   localparam int     PW    = $clog2(H + 1) + YW;
   localparam int     QW    = $clog2(WINDOW_POINTS + 1) + WGW;
   localparam int     IW    = $clog2(SX2 + 1) + YW;
   localparam int     JW    = $clog2(H + 1) + WGW;
   localparam int     SNW   = tlfc_maxi(tlfc_maxi(PW, QW), SA_W) + 1;
   localparam int     INW   = tlfc_maxi(tlfc_maxi(IW, JW), IA_W) + 1;
   localparam int     SQW   = SNW + 8;

   localparam logic signed [SNW-1:0] S_128D   = SNW'(64'sd128 * DIV_L);
   localparam logic signed [SNW-1:0] S_129D   = SNW'(64'sd129 * DIV_L);
   localparam logic signed [INW-1:0] I_65536D = INW'(64'sd65536 * DIV_L);
   localparam logic signed [SQW-1:0] K_P1281  = SQW'(64'sd1281 * DIV_L);
   localparam logic signed [SQW-1:0] K_P5120  = SQW'(64'sd5120 * DIV_L);
   localparam logic signed [SQW-1:0] K_P257   = SQW'(64'sd257 * DIV_L);
   localparam logic signed [SQW-1:0] K_M256   = SQW'(-64'sd256 * DIV_L);
   localparam logic signed [SQW-1:0] K_M1280  = SQW'(-64'sd1280 * DIV_L);
   localparam logic signed [SQW-1:0] K_M1281  = SQW'(-64'sd1281 * DIV_L);
   localparam logic signed [SQW-1:0] K_M5120  = SQW'(-64'sd5120 * DIV_L);

   // First stage: four products with constants.
   logic          v1_ff, v1_in;
   logic [PW-1:0] p_ff, p_in;
   logic [QW-1:0] q_ff, q_in;
   logic [IW-1:0] i_ff, i_in;
   logic [JW-1:0] j_ff, j_in;

   // Second stage: flags and magnitudes.
   logic            v2_ff, v2_in;
   tlfc_flags_type  flags_ff, flags_in;
   logic [SA_W-1:0] smag_ff, smag_in;
   logic [IA_W-1:0] imag_ff, imag_in;

   logic signed [SNW-1:0] s_pos;
   logic signed [SNW-1:0] s_rev;
   logic signed [SQW-1:0] s_q8;
   logic signed [INW-1:0] i_diff;

   // slope numerator = H*Sy - N*W, intercept numerator = SX2*Sy - H*W,
   // where W is the negated sum of x times sample.
   always_comb begin
      v1_in = in_valid;
      p_in  = PW'(in_sy) * PW'(H);
      q_in  = QW'(in_w) * QW'(WINDOW_POINTS);
      i_in  = IW'(in_sy) * IW'(SX2);
      j_in  = JW'(in_w) * JW'(H);
   end

   // Thresholds on the Q8 slope are compared as 256*n against multiples of
   // the divisor, which gives truncation toward zero without dividing.
   always_comb begin
      s_pos  = $signed(SNW'(p_ff)) - $signed(SNW'(q_ff));
      s_rev  = $signed(SNW'(q_ff)) - $signed(SNW'(p_ff));
      s_q8   = $signed({s_pos, 8'b0});
      i_diff = $signed(INW'(i_ff)) - $signed(INW'(j_ff));

      v2_in              = v1_ff;
      flags_in.icpt_neg  = i_diff[INW-1];
      flags_in.icpt_hi   = (i_diff >= I_65536D);
      flags_in.slope_neg = s_pos[SNW-1];
      flags_in.slope_hi  = (s_pos >= S_128D);
      flags_in.slope_lo  = (s_rev >= S_129D);
      flags_in.gt_p1280  = (s_q8 >= K_P1281);
      flags_in.lt_p5120  = (s_q8 < K_P5120);
      flags_in.gt_p256   = (s_q8 >= K_P257);
      flags_in.gt_m256   = (s_q8 > K_M256);
      flags_in.gt_m1280  = (s_q8 > K_M1280);
      flags_in.le_m1281  = (s_q8 <= K_M1281);
      flags_in.gt_m5120  = (s_q8 > K_M5120);
      smag_in = s_pos[SNW-1] ? s_rev[SA_W-1:0] : s_pos[SA_W-1:0];
      imag_in = i_diff[IA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= p_in;
         q_ff     <= q_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         flags_ff <= flags_in;
         smag_ff  <= smag_in;
         imag_ff  <= imag_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_flags = flags_ff;
   assign out_smag  = smag_ff;
   assign out_imag  = imag_ff;

endmodule

`default_nettype wire

@@ hdl/tlfc_cdiv.sv @@
// Three-stage divider by a constant: reciprocal multiply, back multiply, one-step correction.
`default_nettype none

module tlfc_cdiv
   import tlfc_pkg::*;
#(
   parameter int     Q_W     = ICPT_Q_W,
   parameter longint DIVISOR = tlfc_divisor(TLFC_WINDOW_POINTS)
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic [Q_W+$clog2(DIVISOR+1)-1:0]      a_in,
   output logic [Q_W-1:0]                             q_out
);

   localparam int     DW    = $clog2(DIVISOR + 1);
   localparam int     A_W   = Q_W + DW;
   localparam int     SH    = A_W;
   localparam int     M_W   = SH - $clog2(DIVISOR) + 1;
   localparam int     PRW   = A_W + M_W;
   localparam longint RECIP = (64'sd1 << SH) / DIVISOR;

   localparam logic [PRW-1:0] RECIP_X = PRW'(RECIP);
   localparam logic [A_W-1:0] DIV_X   = A_W'(DIVISOR);

   logic [PRW-1:0] prod_ff, prod_in;
   logic [A_W-1:0] a1_ff, a1_in;
   logic [Q_W-1:0] q0_ff, q0_in;
   logic [A_W-1:0] qd_ff, qd_in;
   logic [A_W-1:0] a2_ff, a2_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [A_W-1:0] rem;

   // The estimate from the truncated reciprocal is the true quotient or one
   // below it, since the dividend stays under 2**SH.
   always_comb begin
      prod_in = {{M_W{1'b0}}, a_in} * RECIP_X;
      a1_in   = a_in;
      q0_in   = prod_ff[SH +: Q_W];
      qd_in   = {{DW{1'b0}}, q0_in} * DIV_X;
      a2_in   = a1_ff;
      rem     = a2_ff - qd_ff;
      q_in    = q0_ff + Q_W'(rem >= DIV_X);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         a1_ff   <= a1_in;
         q0_ff   <= q0_in;
         qd_ff   <= qd_in;
         a2_ff   <= a2_in;
         q_ff    <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

`default_nettype wire

@@ hdl/trend_line_fit_classifier_top.sv @@
// Top level of the trend line fit classifier: accumulator, fit pipeline and result register.
// Fit path of a window, from the transaction that carries its last sample: accumulator
//    register, two numerator stages, three divider stages, result register.
// Throughput: one sample transaction per cycle; one result per WINDOW_POINTS samples. The
//    whole pipeline moves only while the result register is empty or being taken.
// Reset (synchronous, active high) clears the sample count, both sums and all valid bits.
`default_nettype none

module trend_line_fit_classifier_top
   import tlfc_pkg::*;
#(
   parameter int WINDOW_POINTS = TLFC_WINDOW_POINTS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [SAMPLE_W-1:0]         req_sample,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [GLUCOSE_W-1:0]             rsp_glucose_now,
   output logic signed [CLIMB_W-1:0]        rsp_climb_rate,
   output logic [CLASS_W-1:0]               rsp_trend_class
);

   localparam longint DIV_L = tlfc_divisor(WINDOW_POINTS);
   localparam int     DW    = $clog2(DIV_L + 1);
   localparam int     YW    = tlfc_sy_width(WINDOW_POINTS);
   localparam int     WGW   = tlfc_w_width(WINDOW_POINTS);
   localparam int     SA_W  = SLOPE_Q_W + DW;
   localparam int     IA_W  = ICPT_Q_W + DW;
   localparam int     DIV_STAGES = 3;

   // Every stage advances together. A held result stalls the whole pipeline,
   // which is the only back pressure the block has.
   logic advance;

   logic            win_valid;
   logic [YW-1:0]   win_sy;
   logic [WGW-1:0]  win_w;

   logic            num_valid;
   tlfc_flags_type  num_flags;
   logic [SA_W-1:0] num_smag;
   logic [IA_W-1:0] num_imag;

   logic [ICPT_Q_W-1:0]  icpt_q;
   logic [SLOPE_Q_W-1:0] slope_q;

   // Valid bits and flags ride beside the two dividers.
   logic [DIV_STAGES-1:0] dv_ff, dv_in;
   tlfc_flags_type        fl_ff [DIV_STAGES];
   tlfc_flags_type        fl_in [DIV_STAGES];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [GLUCOSE_W-1:0]        glucose_ff, glucose_in;
   logic signed [CLIMB_W-1:0]   climb_ff, climb_in;
   logic [CLASS_W-1:0]          class_ff, class_in;

   tlfc_flags_type fin;

   assign advance = !rsp_valid_ff || rsp_ready;

   tlfc_accum #(
      .WINDOW_POINTS (WINDOW_POINTS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_valid),
      .in_sample (req_sample),
      .win_valid (win_valid),
      .win_sy    (win_sy),
      .win_w     (win_w)
   );

   tlfc_numer #(
      .WINDOW_POINTS (WINDOW_POINTS)
   ) u_numer (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (win_valid),
      .in_sy     (win_sy),
      .in_w      (win_w),
      .out_valid (num_valid),
      .out_flags (num_flags),
      .out_smag  (num_smag),
      .out_imag  (num_imag)
   );

   // Intercept quotient. Dividends out of range are replaced by the clamp
   // later, so their quotient does not matter.
   tlfc_cdiv #(
      .Q_W     (ICPT_Q_W),
      .DIVISOR (DIV_L)
   ) u_div_icpt (
      .clock (clock),
      .en    (advance),
      .a_in  (num_imag),
      .q_out (icpt_q)
   );

   // Slope magnitude quotient, valid while the slope is not saturated.
   tlfc_cdiv #(
      .Q_W     (SLOPE_Q_W),
      .DIVISOR (DIV_L)
   ) u_div_slope (
      .clock (clock),
      .en    (advance),
      .a_in  (num_smag),
      .q_out (slope_q)
   );

   always_comb begin
      dv_in    = {dv_ff[DIV_STAGES-2:0], num_valid};
      fl_in[0] = num_flags;
      for (int s = 1; s < DIV_STAGES; s++) begin
         fl_in[s] = fl_ff[s-1];
      end
   end

   // Result formatting: clamp the intercept, saturate and sign the slope, and
   // pick the trend class with the same precedence as the threshold list. The
   // gaps at exactly minus five and at twenty or more fall through as intended.
   always_comb begin
      fin          = fl_ff[DIV_STAGES-1];
      rsp_valid_in = dv_ff[DIV_STAGES-1];

      priority if (fin.icpt_hi) begin
         glucose_in = '1;
      end else if (fin.icpt_neg) begin
         glucose_in = '0;
      end else begin
         glucose_in = icpt_q;
      end

      priority if (fin.slope_hi) begin
         climb_in = 8'sd127;
      end else if (fin.slope_lo) begin
         climb_in = -8'sd128;
      end else if (fin.slope_neg) begin
         climb_in = $signed(CLIMB_W'(8'd0 - slope_q));
      end else begin
         climb_in = $signed(CLIMB_W'(slope_q));
      end

      priority if (fin.gt_p1280 && fin.lt_p5120) begin
         class_in = TREND_RISING;
      end else if (fin.gt_p256) begin
         class_in = TREND_RISING_SLOW;
      end else if (fin.gt_m256) begin
         class_in = TREND_CONSTANT;
      end else if (fin.gt_m1280) begin
         class_in = TREND_FALLING_SLOW;
      end else if (fin.le_m1281 && fin.gt_m5120) begin
         class_in = TREND_FALLING;
      end else begin
         class_in = TREND_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            fl_ff[s] <= fl_in[s];
         end
         glucose_ff <= glucose_in;
         climb_ff   <= climb_in;
         class_ff   <= class_in;
      end
   end

   assign req_ready       = advance;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glucose_now = glucose_ff;
   assign rsp_climb_rate  = climb_ff;
   assign rsp_trend_class = class_ff;

   // A held result must stall sample intake.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("sample transaction taken while a result is held");

   // A new result comes only from a fit that left the divider stages.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dv_ff[DIV_STAGES-1]))
      else $error("result appeared without a fit in flight");

   // Rising means a slope of five up to nineteen.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trend_class == TREND_RISING) |->
      (rsp_climb_rate >= 8'sd5 && rsp_climb_rate <= 8'sd19))
      else $error("rising class disagrees with slope");

   // Falling means a slope of minus nineteen down to minus five.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trend_class == TREND_FALLING) |->
      (rsp_climb_rate >= -8'sd19 && rsp_climb_rate <= -8'sd5))
      else $error("falling class disagrees with slope");

   // Constant means the truncated slope is zero or one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trend_class == TREND_CONSTANT) |->
      (rsp_climb_rate == 8'sd0 || rsp_climb_rate == 8'sd1))
      else $error("constant class disagrees with slope");

endmodule

`default_nettype wire

@@ tb/sv/trend_fit_checker.sv @@
// Checker for the trend line fit classifier: predicts each window's fit and compares the results.
`timescale 1ns / 100ps

module trend_fit_checker
   import tlfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [SAMPLE_W-1:0]       req_sample,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [GLUCOSE_W-1:0]      rsp_glucose_now,
   input  logic signed [CLIMB_W-1:0] rsp_climb_rate,
   input  logic [CLASS_W-1:0]        rsp_trend_class,
   output int                        mismatch_count,
   output int                        fits_pending
);

   // Fixed sums of the x positions -(N-1)..0 and the resulting fit divisor.
   localparam longint POINTS    = TLFC_WINDOW_POINTS;
   localparam longint X_SUM     = -(POINTS * (POINTS - 1)) / 2;
   localparam longint X_SQ_SUM  = (POINTS - 1) * POINTS * (2 * POINTS - 1) / 6;
   localparam longint FIT_DIV   = POINTS * X_SQ_SUM - X_SUM * X_SUM;

   typedef struct {
      logic [GLUCOSE_W-1:0]      glucose_now;
      logic signed [CLIMB_W-1:0] climb_rate;
      logic [CLASS_W-1:0]        trend_class;
   } line_fit_type;

   line_fit_type expected_fits [$];
   line_fit_type fit;
   line_fit_type seen;
   int        window_fill;
   int        errors_seen;
   longint    value_sum;
   longint    weighted_sum;
   longint    x_pos;
   longint    slope_num;
   longint    icpt;
   longint    slope;
   longint    slope_q8;

   task automatic report_mismatch(input string what);
      $display("%0t ns: trend fit mismatch: %s", $time, what);
      errors_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_fill  = 0;
         value_sum    = 0;
         weighted_sum = 0;
         expected_fits.delete();
      end else begin
         if (req_valid && req_ready) begin
            x_pos        = longint'(window_fill) - (POINTS - 1);
            value_sum    = value_sum + longint'(req_sample);
            weighted_sum = weighted_sum + x_pos * longint'(req_sample);
            window_fill++;
            if (window_fill == POINTS) begin
               slope_num = POINTS * weighted_sum - X_SUM * value_sum;
               icpt      = (value_sum * X_SQ_SUM - X_SUM * weighted_sum) / FIT_DIV;
               slope     = slope_num / FIT_DIV;
               slope_q8  = (slope_num * 256) / FIT_DIV;
               if (icpt < 0) icpt = 0;
               if (icpt > 65535) icpt = 65535;
               if (slope < -128) slope = -128;
               if (slope > 127) slope = 127;
               fit.glucose_now = icpt[GLUCOSE_W-1:0];
               fit.climb_rate  = slope[CLIMB_W-1:0];
               // The class bands leave gaps: exactly -5 and anything at or past
               // +/-20 fall through to a slower band or to unknown.
               if (slope_q8 > 1280 && slope_q8 < 5120)
                  fit.trend_class = TREND_RISING;
               else if (slope_q8 > 256)
                  fit.trend_class = TREND_RISING_SLOW;
               else if (slope_q8 > -256)
                  fit.trend_class = TREND_CONSTANT;
               else if (slope_q8 > -1280)
                  fit.trend_class = TREND_FALLING_SLOW;
               else if (slope_q8 < -1280 && slope_q8 > -5120)
                  fit.trend_class = TREND_FALLING;
               else
                  fit.trend_class = TREND_UNKNOWN;
               expected_fits.push_back(fit);
               window_fill  = 0;
               value_sum    = 0;
               weighted_sum = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_fits.size() == 0) begin
               report_mismatch("result transaction with no completed window");
            end else begin
               seen = expected_fits.pop_front();
               if (rsp_glucose_now !== seen.glucose_now)
                  report_mismatch($sformatf("glucose_now got %0d expected %0d",
                                            rsp_glucose_now, seen.glucose_now));
               if (rsp_climb_rate !== seen.climb_rate)
                  report_mismatch($sformatf("climb_rate got %0d expected %0d",
                                            rsp_climb_rate, seen.climb_rate));
               if (rsp_trend_class !== seen.trend_class)
                  report_mismatch($sformatf("trend_class got %0d expected %0d",
                                            rsp_trend_class, seen.trend_class));
            end
         end
      end
      fits_pending   <= expected_fits.size();
      mismatch_count <= errors_seen;
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the trend line fit classifier: clock, reset, sample and result traffic.
`timescale 1ns / 100ps

module tb_top
   import tlfc_pkg::*;
();

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_W-1:0]       req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [GLUCOSE_W-1:0]      rsp_glucose_now;
   logic signed [CLIMB_W-1:0] rsp_climb_rate;
   logic [CLASS_W-1:0]        rsp_trend_class;
   int                        mismatch_count;
   int                        fits_pending;

   // When set, the sample sender offers back-to-back transactions for a whole window.
   bit                        sender_calm = 1'b0;

   // Slopes that sit on or right next to a class boundary or the saturation limits.
   // An exact ramp of slope m fits to slope m, so these land on the boundaries exactly.
   int boundary_slopes [0:20] = '{0, 1, -1, 2, -2, 4, 5, 6, -4, -5, -6,
                                  19, 20, 21, -19, -20, -21, 127, 128, -128, -129};

   trend_line_fit_classifier_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_glucose_now (rsp_glucose_now),
      .rsp_climb_rate  (rsp_climb_rate),
      .rsp_trend_class (rsp_trend_class)
   );

   trend_fit_checker fit_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_glucose_now (rsp_glucose_now),
      .rsp_climb_rate  (rsp_climb_rate),
      .rsp_trend_class (rsp_trend_class),
      .mismatch_count  (mismatch_count),
      .fits_pending    (fits_pending)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Reset is held at the start and never asserted again.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Safety net: the slowest legal run is a few hundred microseconds.
   initial begin
      #3_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Saturating conversion of a computed sample value to the 16-bit field.
   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int value);
      if (value < 0) return '0;
      if (value > 65535) return '1;
      return value[SAMPLE_W-1:0];
   endfunction

   // Offers one sample transaction after a random idle gap and returns once it is
   // accepted. With a zero gap valid simply stays high and the payload moves on, so
   // valid is never dropped and raised again at the same edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Result receiver. It draws a wait before each result, with calm stretches of no
   // waiting, and once holds ready low for a long stretch while the sender keeps
   // going, so that the fit pipeline backs up and the block stalls its sample input.
   initial begin
      int gap;
      int results_taken;
      bit receiver_calm;
      do @(posedge clock); while (reset);
      results_taken = 0;
      receiver_calm = 1'b0;
      forever begin
         if (results_taken % 8 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         if (results_taken == 12)
            gap = 2500;
         else
            gap = receiver_calm ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
      end
   end

   // Sample sender and verdict.
   initial begin
      int                  items_sent;
      int                  kind;
      int                  slope;
      int                  base;
      int                  noise_span;
      int                  split;
      int                  level;
      int                  raw;
      logic [SAMPLE_W-1:0] lo_level;
      logic [SAMPLE_W-1:0] hi_level;
      logic [SAMPLE_W-1:0] value;

      do @(posedge clock); while (reset);

      // Directed windows. The first alternates the two extreme sample values, so the
      // fit sees every bit at both levels. The second is a full-scale drop to zero
      // halfway through: the intercept comes out negative and clamps to zero, and the
      // slope saturates at its negative limit.
      for (int k = 0; k < 16; k++) send_sample(k[0] ? 16'hFFFF : 16'h0000);
      for (int k = 0; k < 16; k++) send_sample(k < 8 ? 16'hFFFF : 16'h0000);
      items_sent = 32;

      // Random windows, always complete, each drawn from one of a few shapes:
      // plain noise, noisy ramps over the whole slope range, exact ramps on the class
      // boundaries, steps between two levels that are mostly the extremes (clamped
      // intercepts and saturated slopes), and flat windows with a little jitter.
      while (items_sent < 1150) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         kind        = $urandom_range(0, 9);
         slope       = 0;
         base        = 0;
         noise_span  = 0;
         split       = $urandom_range(1, 15);
         level       = $urandom_range(0, 65535);
         lo_level    = ($urandom_range(0, 2) == 0) ? 16'h0000 :
                       ($urandom_range(0, 1) == 0) ? 16'hFFFF :
                       SAMPLE_W'($urandom_range(0, 65535));
         hi_level    = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
                       ($urandom_range(0, 1) == 0) ? 16'h0000 :
                       SAMPLE_W'($urandom_range(0, 65535));
         if (kind >= 2 && kind <= 7) begin
            if (kind <= 4) begin
               slope      = $urandom_range(0, 280);
               slope      = slope - 140;
               noise_span = 3;
            end else begin
               slope = boundary_slopes[$urandom_range(0, 20)];
            end
            // Keep the whole ramp inside the sample range: the oldest sample sits
            // fifteen steps before the newest one.
            if (slope >= 0)
               base = $urandom_range(15 * slope, 65535);
            else
               base = $urandom_range(0, 65535 + 15 * slope);
         end
         for (int k = 0; k < 16; k++) begin
            case (kind)
               2, 3, 4, 5, 6, 7: begin
                  raw   = $urandom_range(0, noise_span);
                  value = clamp_sample(base + slope * (k - 15) + raw);
               end
               8: value = (k < split) ? lo_level : hi_level;
               9: begin
                  raw   = $urandom_range(0, 4);
                  value = clamp_sample(level + raw - 2);
               end
               default: value = SAMPLE_W'($urandom_range(0, 65535));
            endcase
            send_sample(value);
         end
         items_sent += 16;
      end
      req_valid <= 1'b0;

      // Let the last window's fit drain through the pipeline, then allow a few more
      // cycles for anything unexpected to show up on the result channel.
      @(posedge clock);
      while (fits_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && fits_pending == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tlfc_pkg.sv
hdl/tlfc_accum.sv
hdl/tlfc_numer.sv
hdl/tlfc_cdiv.sv
hdl/trend_line_fit_classifier_top.sv
tb/sv/trend_fit_checker.sv
tb/sv/tb_top.sv
